/* src/heading_pid_steering_macros.svh */
// assertion helpers shared by the heading pid steering modules
`ifndef HEADING_PID_STEERING_MACROS_SVH
`define HEADING_PID_STEERING_MACROS_SVH

`ifndef SYNTHESIS
`define HPS_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define HPS_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HPS_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HPS_ASSERT(lbl, expr)
`define HPS_IMPLY(lbl, ante, cons)
`define HPS_NEXT(lbl, ante, cons)
`endif

`endif

/* src/hps_pkg.sv */
package hps_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_AIM_HEADING    = 3'd0,
    REG_GAIN_PROP      = 3'd1,
    REG_GAIN_RATE      = 3'd2,
    REG_GAIN_INTEGRAL  = 3'd3,
    REG_DRIVE_CENTER   = 3'd4
  } reg_index_t;

  localparam logic [15:0] NEUTRAL_RESET = 16'd1500;

  // half, full, one and a half and two turns in centidegrees
  localparam logic signed [17:0] HALF_TURN     = 18'sd18000;
  localparam logic signed [17:0] FULL_TURN     = 18'sd36000;
  localparam logic signed [17:0] ONE_HALF_TURN = 18'sd54000;
  localparam logic signed [17:0] TWO_TURNS     = 18'sd72000;

  localparam logic signed [31:0] SUM_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SUM_MIN = 32'sh8000_0000;

  // one beat from the error stage to the drive stage
  typedef struct packed {
    logic signed [15:0] err;
    logic signed [16:0] rate;
    logic signed [31:0] sum;
  } err_beat_t;

endpackage

/* src/hps_error_stage.sv */
`include "heading_pid_steering_macros.svh"

module hps_error_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              heading_valid,
  input  logic [15:0]       heading_measured,
  output logic              in_ready,
  input  logic [15:0]       aim_heading,
  input  logic              beat_ready,
  output logic              beat_valid,
  output hps_pkg::err_beat_t beat
);

  logic        meas_valid;
  logic [15:0] meas;
  logic signed [15:0] previous_error;
  logic signed [31:0] accumulated_error;

  logic signed [17:0] diff;
  logic signed [17:0] wrapped;
  logic signed [15:0] err_next;
  logic signed [16:0] rate_next;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_next;
  logic               meas_fire;

  assign meas_fire = meas_valid && (!beat_valid || beat_ready);
  assign in_ready  = !meas_valid || meas_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_valid <= 1'b0;
    end else if (in_ready) begin
      meas_valid <= heading_valid;
    end
    if (in_ready && heading_valid) begin
      meas <= heading_measured;
    end
  end

  // wrap into -18000..+18000, at most two turns away
  always_comb begin
    diff = $signed({2'b00, aim_heading}) - $signed({2'b00, meas});
    if (diff > hps_pkg::ONE_HALF_TURN) begin
      wrapped = diff - hps_pkg::TWO_TURNS;
    end else if (diff > hps_pkg::HALF_TURN) begin
      wrapped = diff - hps_pkg::FULL_TURN;
    end else if (diff < -hps_pkg::ONE_HALF_TURN) begin
      wrapped = diff + hps_pkg::TWO_TURNS;
    end else if (diff < -hps_pkg::HALF_TURN) begin
      wrapped = diff + hps_pkg::FULL_TURN;
    end else begin
      wrapped = diff;
    end
    err_next  = wrapped[15:0];
    rate_next = {err_next[15], err_next} - {previous_error[15], previous_error};
    sum_wide  = {accumulated_error[31], accumulated_error} + {{17{err_next[15]}}, err_next};
    if (sum_wide[32] != sum_wide[31]) begin
      sum_next = sum_wide[32] ? hps_pkg::SUM_MIN : hps_pkg::SUM_MAX;
    end else begin
      sum_next = sum_wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid        <= 1'b0;
      previous_error    <= '0;
      accumulated_error <= '0;
    end else begin
      if (!beat_valid || beat_ready) begin
        beat_valid <= meas_valid;
      end
      if (meas_fire) begin
        previous_error    <= err_next;
        accumulated_error <= sum_next;
      end
    end
    if (meas_fire) begin
      beat.err  <= err_next;
      beat.rate <= rate_next;
      beat.sum  <= sum_next;
    end
  end

  `HPS_IMPLY(a_err_range, beat_valid,
    ($signed(beat.err) <= 16'sd18000) && ($signed(beat.err) >= -16'sd18000))
  `HPS_NEXT(a_state_holds, !meas_fire,
    $stable(accumulated_error) && $stable(previous_error))

endmodule

/* src/hps_drive_stage.sv */
`include "heading_pid_steering_macros.svh"

module hps_drive_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               beat_valid,
  input  hps_pkg::err_beat_t beat,
  output logic               beat_ready,
  input  logic signed [15:0] gain_prop,
  input  logic signed [15:0] gain_rate,
  input  logic signed [15:0] gain_integral,
  input  logic [15:0]        drive_center,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [15:0]        steering_pwm,
  output logic signed [15:0] heading_error,
  output logic signed [16:0] error_rate,
  output logic signed [31:0] error_sum
);

  logic signed [31:0] p_prop;
  logic signed [32:0] p_rate;
  logic signed [47:0] p_int;
  logic signed [49:0] total;
  logic signed [49:0] drive;
  logic [15:0]        pwm_next;
  logic               beat_fire;

  assign beat_ready = !result_valid || !result_stall;
  assign beat_fire  = beat_valid && beat_ready;

  always_comb begin
    p_prop = gain_prop * $signed(beat.err);
    p_rate = gain_rate * $signed(beat.rate);
    p_int  = gain_integral * $signed(beat.sum);
    total  = {{18{p_prop[31]}}, p_prop} + {{17{p_rate[32]}}, p_rate}
           + {{2{p_int[47]}}, p_int};
    drive  = $signed({26'd0, drive_center, 8'd0}) - total;
    if (drive[49]) begin
      pwm_next = '0;
    end else if (|drive[48:24]) begin
      pwm_next = 16'hffff;
    end else begin
      pwm_next = drive[23:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (beat_ready) begin
      result_valid <= beat_valid;
    end
    if (beat_fire) begin
      steering_pwm  <= pwm_next;
      heading_error <= beat.err;
      error_rate    <= beat.rate;
      error_sum     <= beat.sum;
    end
  end

  `HPS_NEXT(a_zero_gain_neutral,
    beat_fire && gain_prop == 16'sd0 && gain_rate == 16'sd0 && gain_integral == 16'sd0,
    steering_pwm == $past(drive_center))

endmodule

/* src/heading_pid_steering.sv */
// heading hold pid steering controller
// heading channel: heading_valid / heading_stall carry one measured heading
// (centidegrees) per beat, one beat per control tick
// result channel: result_valid / result_stall carry steering_pwm, the wrapped
// heading_error, error_rate and the saturated error_sum, one beat per input beat
// config channel: cfg_valid / cfg_ready write cfg_data to register cfg_index
// (0 target, 1 prop gain, 2 rate gain, 3 integral gain, 4 neutral);
// cfg_ready is always high, unknown indexes are dropped, write only when idle
// path: each heading beat that is taken passes through an input register, the
// error/state register and the output register before its result is shown
// throughput: one beat per cycle while result_stall does not hold the output
// a stalled result holds; the stages behind it keep filling, and heading_stall
// rises only once every stage holds a beat
// reset clears the error history, the integral, all gains and the target,
// and sets the neutral drive to 1500; no item is in flight after reset
`include "heading_pid_steering_macros.svh"

module heading_pid_steering (
  input  logic               clk,
  input  logic               rst,
  input  logic               heading_valid,
  output logic               heading_stall,
  input  logic [15:0]        heading_measured,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [15:0]        steering_pwm,
  output logic signed [15:0] heading_error,
  output logic signed [16:0] error_rate,
  output logic signed [31:0] error_sum,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [15:0]        aim_heading;
  logic signed [15:0] gain_prop;
  logic signed [15:0] gain_rate;
  logic signed [15:0] gain_integral;
  logic [15:0]        drive_center;

  logic               in_ready;
  logic               beat_valid;
  logic               beat_ready;
  hps_pkg::err_beat_t beat;

  assign cfg_ready     = 1'b1;
  assign heading_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      aim_heading    <= '0;
      gain_prop      <= '0;
      gain_rate      <= '0;
      gain_integral  <= '0;
      drive_center   <= hps_pkg::NEUTRAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hps_pkg::REG_AIM_HEADING:    aim_heading    <= cfg_data;
        hps_pkg::REG_GAIN_PROP:      gain_prop      <= cfg_data;
        hps_pkg::REG_GAIN_RATE:      gain_rate      <= cfg_data;
        hps_pkg::REG_GAIN_INTEGRAL:  gain_integral  <= cfg_data;
        hps_pkg::REG_DRIVE_CENTER:   drive_center   <= cfg_data;
        default: ;
      endcase
    end
  end

  hps_error_stage u_error (
    .clk              (clk),
    .rst              (rst),
    .heading_valid    (heading_valid),
    .heading_measured (heading_measured),
    .in_ready         (in_ready),
    .aim_heading      (aim_heading),
    .beat_ready       (beat_ready),
    .beat_valid       (beat_valid),
    .beat             (beat)
  );

  hps_drive_stage u_drive (
    .clk           (clk),
    .rst           (rst),
    .beat_valid    (beat_valid),
    .beat          (beat),
    .beat_ready    (beat_ready),
    .gain_prop     (gain_prop),
    .gain_rate     (gain_rate),
    .gain_integral (gain_integral),
    .drive_center  (drive_center),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .steering_pwm  (steering_pwm),
    .heading_error (heading_error),
    .error_rate    (error_rate),
    .error_sum     (error_sum)
  );

  // input backs up only when every stage is full and the output is held
  `HPS_IMPLY(a_stall_when_full, heading_stall,
    result_valid && result_stall && beat_valid)

endmodule
